// ----- hw/rtl/lpht_pkg.sv -----
package lpht_pkg;

    localparam int KEY_W = 64;
    localparam int LEN_W = 4;
    localparam int VAL_W = 32;
    localparam int CAP_W = 7;
    localparam int HASH_W = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd50;
    localparam logic [HASH_W-1:0] HASH_MUL = 32'd13;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_LIVE  = 2'd1,
        MARK_TOMB  = 2'd2
    } t_mark;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_EMPTY_KEY   = 3'd1,
        ST_FULL        = 3'd2,
        ST_DUP         = 3'd3,
        ST_TABLE_EMPTY = 3'd4,
        ST_NOT_FOUND   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef struct packed {
        t_mark              mark;
        logic [LEN_W-1:0]   len;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
    } t_slot;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_FETCH,
        S_CHECK,
        S_RESP
    } t_state;

    typedef enum logic [1:0] {
        H_IDLE,
        H_HASH,
        H_MOD
    } t_hstate;

endpackage

// ----- hw/rtl/lpht_home.sv -----
module lpht_home #(
    parameter int SW = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lpht_pkg::KEY_W-1:0] i_key,
    input  logic [lpht_pkg::LEN_W-1:0] i_len,
    input  logic [lpht_pkg::CAP_W-1:0] i_cap,
    output logic                       o_done,
    output logic [SW-1:0]              o_slot
);

    lpht_pkg::t_hstate r_state, n_state;
    logic [lpht_pkg::HASH_W-1:0] r_h, n_h;
    logic [lpht_pkg::KEY_W-1:0]  r_key, n_key;
    logic [lpht_pkg::LEN_W-1:0]  r_len, n_len;
    logic [lpht_pkg::CAP_W-1:0]  r_cap, n_cap;
    logic [2:0]                  r_idx, n_idx;
    logic [4:0]                  r_bit, n_bit;
    logic [lpht_pkg::CAP_W-1:0]  r_rem, n_rem;
    logic                        r_done, n_done;
    logic [SW-1:0]               r_slot, n_slot;

    logic [7:0]                  chr;
    logic [lpht_pkg::CAP_W:0]    rem_sh;
    logic [lpht_pkg::CAP_W:0]    rem_nx;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lpht_pkg::H_IDLE: begin
                if (i_start) n_state = lpht_pkg::H_HASH;
            end
            lpht_pkg::H_HASH: begin
                if ({1'b0, r_idx} + 4'd1 == r_len) n_state = lpht_pkg::H_MOD;
            end
            lpht_pkg::H_MOD: begin
                if (r_bit == 5'd31) n_state = lpht_pkg::H_IDLE;
            end
            default: n_state = lpht_pkg::H_IDLE;
        endcase
    end

    // one character per cycle, then restoring remainder one bit per cycle
    always_comb begin
        n_h    = r_h;
        n_key  = r_key;
        n_len  = r_len;
        n_cap  = r_cap;
        n_idx  = r_idx;
        n_bit  = r_bit;
        n_rem  = r_rem;
        n_done = 1'b0;
        n_slot = r_slot;
        chr    = r_key[8*r_idx +: 8];
        rem_sh = {r_rem, r_h[lpht_pkg::HASH_W-1]};
        rem_nx = rem_sh;
        if (rem_sh >= {1'b0, r_cap}) rem_nx = rem_sh - {1'b0, r_cap};
        unique case (r_state)
            lpht_pkg::H_IDLE: begin
                if (i_start) begin
                    n_h   = 32'd1;
                    n_key = i_key;
                    n_len = i_len;
                    n_cap = i_cap;
                    n_idx = '0;
                end
            end
            lpht_pkg::H_HASH: begin
                n_h   = r_h * lpht_pkg::HASH_MUL + {{24{chr[7]}}, chr};
                n_idx = r_idx + 3'd1;
                n_bit = '0;
                n_rem = '0;
            end
            lpht_pkg::H_MOD: begin
                n_rem = rem_nx[lpht_pkg::CAP_W-1:0];
                n_h   = {r_h[lpht_pkg::HASH_W-2:0], 1'b0};
                n_bit = r_bit + 5'd1;
                if (r_bit == 5'd31) begin
                    n_done = 1'b1;
                    n_slot = SW'(rem_nx[lpht_pkg::CAP_W-1:0]);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpht_pkg::H_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_h    <= n_h;
        r_key  <= n_key;
        r_len  <= n_len;
        r_cap  <= n_cap;
        r_idx  <= n_idx;
        r_bit  <= n_bit;
        r_rem  <= n_rem;
        r_slot <= n_slot;
    end

    assign o_done = r_done;
    assign o_slot = r_slot;

endmodule

// ----- hw/rtl/linear_probe_hash_table.sv -----
// Open-addressing key/value table with linear probing.
// Input channel: i_in_valid / o_in_stall carries operation (insert, remove,
// lookup), a key of up to 8 bytes with its length, and the insert value.
// Output channel: o_out_valid / i_out_stall carries status and value_out,
// exactly one result item per input item, in order.
// Config: i_cfg_valid / o_cfg_ready writes capacity; always ready. Write it
// only while the block is idle.
// Flow: an item that fails an early check (empty key, full, empty table)
// or is a no-op goes from accept straight to the response state. Otherwise
// the home slot unit hashes the key character by character and then forms
// the remainder bit-serially, and each probed slot takes a registered
// memory read, then a compare. One item at a time; o_in_stall is high
// from accept until the result is loaded.
// The result sits in an output register, so the next item is taken while it
// waits; the block holds in its response state if that register is still
// full when the next result is ready.
// Reset: capacity returns to 50 and the count to zero; then a clearing pass
// marks all TABLE_SLOTS slots empty, one per cycle, with o_in_stall high.
module linear_probe_hash_table #(
    parameter int TABLE_SLOTS   = 64,
    parameter int KEY_CHARS_MAX = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [6:0]          i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_operation,
    input  logic [63:0]         i_key_chars,
    input  logic [3:0]          i_key_length,
    input  logic signed [31:0]  i_value_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [2:0]          o_status,
    output logic signed [31:0]  o_value_out
);

    localparam int SW = $clog2(TABLE_SLOTS);
    localparam int CW = lpht_pkg::CAP_W;

    lpht_pkg::t_state r_state, n_state;

    // configuration and occupancy
    logic [CW-1:0] r_cap, n_cap;
    logic [CW-1:0] r_occ, n_occ;
    logic [CW-1:0] cap_eff;

    // request being served
    lpht_pkg::t_op              r_op, n_op;
    logic [lpht_pkg::KEY_W-1:0] r_key, n_key;
    logic [lpht_pkg::LEN_W-1:0] r_len, n_len;
    logic [lpht_pkg::VAL_W-1:0] r_val, n_val;
    logic                       r_early, n_early;
    lpht_pkg::t_status          r_st, n_st;

    // probe walk
    logic [SW-1:0]              r_p, n_p;
    logic [CW-1:0]              r_n, n_n;
    logic                       r_found, n_found;
    logic [SW-1:0]              r_fpos, n_fpos;
    logic [lpht_pkg::VAL_W-1:0] r_fval, n_fval;
    logic                       r_free_ok, n_free_ok;
    logic [SW-1:0]              r_free, n_free;
    logic [SW-1:0]              r_clr, n_clr;

    // result register
    logic                       r_out_valid, n_out_valid;
    lpht_pkg::t_status          r_out_st, n_out_st;
    logic [lpht_pkg::VAL_W-1:0] r_out_val, n_out_val;

    // slot memory
    lpht_pkg::t_slot mem [TABLE_SLOTS];
    lpht_pkg::t_slot r_rd;
    logic            mem_we;
    logic [SW-1:0]   mem_wa;
    lpht_pkg::t_slot mem_wd;

    // decoded input item
    logic [lpht_pkg::LEN_W-1:0] len_c;
    logic [lpht_pkg::KEY_W-1:0] key_m;
    logic                       in_acc;
    logic                       out_free;
    logic                       hit;
    logic                       lap;
    logic                       u_start;
    logic                       u_done;
    logic [SW-1:0]              u_slot;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != lpht_pkg::S_IDLE);
    assign in_acc      = i_in_valid && (r_state == lpht_pkg::S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;

    // capacity of 0 acts as 1, anything above the table size as the table size
    always_comb begin
        cap_eff = r_cap;
        if (r_cap == '0) cap_eff = CW'(1);
        else if (32'(r_cap) > 32'(TABLE_SLOTS)) cap_eff = CW'(TABLE_SLOTS);
    end

    // clamp length and zero the bytes past it
    always_comb begin
        len_c = i_key_length;
        if (i_key_length > lpht_pkg::LEN_W'(KEY_CHARS_MAX))
            len_c = lpht_pkg::LEN_W'(KEY_CHARS_MAX);
        for (int b = 0; b < 8; b++) begin
            key_m[8*b +: 8] = (lpht_pkg::LEN_W'(b) < len_c) ? i_key_chars[8*b +: 8] : 8'h00;
        end
    end

    assign hit = (r_rd.mark == lpht_pkg::MARK_LIVE) && (r_rd.len == r_len) &&
                 (r_rd.key == r_key);
    assign lap = (r_n + CW'(1) == cap_eff);

    lpht_home #(
        .SW(SW)
    ) u_home (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (u_start),
        .i_key   (key_m),
        .i_len   (len_c),
        .i_cap   (cap_eff),
        .o_done  (u_done),
        .o_slot  (u_slot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lpht_pkg::S_CLEAR: begin
                if (r_clr == SW'(TABLE_SLOTS - 1)) n_state = lpht_pkg::S_IDLE;
            end
            lpht_pkg::S_IDLE: begin
                if (in_acc) n_state = n_early ? lpht_pkg::S_RESP : lpht_pkg::S_HASH;
            end
            lpht_pkg::S_HASH: begin
                if (u_done) n_state = lpht_pkg::S_FETCH;
            end
            lpht_pkg::S_FETCH: n_state = lpht_pkg::S_CHECK;
            lpht_pkg::S_CHECK: begin
                if (hit || r_rd.mark == lpht_pkg::MARK_EMPTY || lap)
                    n_state = lpht_pkg::S_RESP;
                else
                    n_state = lpht_pkg::S_FETCH;
            end
            lpht_pkg::S_RESP: begin
                if (out_free) n_state = lpht_pkg::S_IDLE;
            end
            default: n_state = lpht_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cap       = r_cap;
        n_occ       = r_occ;
        n_op        = r_op;
        n_key       = r_key;
        n_len       = r_len;
        n_val       = r_val;
        n_early     = r_early;
        n_st        = r_st;
        n_p         = r_p;
        n_n         = r_n;
        n_found     = r_found;
        n_fpos      = r_fpos;
        n_fval      = r_fval;
        n_free_ok   = r_free_ok;
        n_free      = r_free;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_st    = r_out_st;
        n_out_val   = r_out_val;
        mem_we      = 1'b0;
        mem_wa      = r_p;
        mem_wd      = '0;
        u_start     = 1'b0;

        if (i_cfg_valid) n_cap = i_cfg_data;

        unique case (r_state)
            lpht_pkg::S_CLEAR: begin
                mem_we      = 1'b1;
                mem_wa      = r_clr;
                mem_wd.mark = lpht_pkg::MARK_EMPTY;
                n_clr       = r_clr + SW'(1);
            end
            lpht_pkg::S_IDLE: begin
                n_early = 1'b1;
                n_st    = lpht_pkg::ST_OK;
                case (lpht_pkg::t_op'(i_operation))
                    lpht_pkg::OP_INSERT: begin
                        if (len_c == '0) n_st = lpht_pkg::ST_EMPTY_KEY;
                        else if (r_occ >= cap_eff) n_st = lpht_pkg::ST_FULL;
                        else n_early = 1'b0;
                    end
                    lpht_pkg::OP_REMOVE: begin
                        if (r_occ == '0) n_st = lpht_pkg::ST_TABLE_EMPTY;
                        else if (len_c == '0) n_st = lpht_pkg::ST_NOT_FOUND;
                        else n_early = 1'b0;
                    end
                    lpht_pkg::OP_LOOKUP: begin
                        if (len_c == '0) n_st = lpht_pkg::ST_NOT_FOUND;
                        else n_early = 1'b0;
                    end
                    default: ;
                endcase
                if (in_acc) begin
                    n_op      = lpht_pkg::t_op'(i_operation);
                    n_key     = key_m;
                    n_len     = len_c;
                    n_val     = i_value_in;
                    n_found   = 1'b0;
                    n_free_ok = 1'b0;
                    u_start   = !n_early;
                end
            end
            lpht_pkg::S_HASH: begin
                if (u_done) begin
                    n_p = u_slot;
                    n_n = '0;
                end
            end
            lpht_pkg::S_FETCH: ;
            lpht_pkg::S_CHECK: begin
                if (hit) begin
                    n_found = 1'b1;
                    n_fpos  = r_p;
                    n_fval  = r_rd.value;
                end else begin
                    // first non-live slot from home is where an insert lands
                    if (r_rd.mark != lpht_pkg::MARK_LIVE && !r_free_ok) begin
                        n_free_ok = 1'b1;
                        n_free    = r_p;
                    end
                    if (r_rd.mark != lpht_pkg::MARK_EMPTY && !lap) begin
                        n_n = r_n + CW'(1);
                        n_p = (32'(r_p) + 32'd1 == 32'(cap_eff)) ? '0 : r_p + SW'(1);
                    end
                end
            end
            lpht_pkg::S_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_val   = '0;
                    n_out_st    = r_st;
                    if (!r_early) begin
                        case (r_op)
                            lpht_pkg::OP_INSERT: begin
                                if (r_found) begin
                                    n_out_st = lpht_pkg::ST_DUP;
                                end else if (r_free_ok) begin
                                    n_out_st     = lpht_pkg::ST_OK;
                                    mem_we       = 1'b1;
                                    mem_wa       = r_free;
                                    mem_wd.mark  = lpht_pkg::MARK_LIVE;
                                    mem_wd.len   = r_len;
                                    mem_wd.key   = r_key;
                                    mem_wd.value = r_val;
                                    n_occ        = r_occ + CW'(1);
                                end else begin
                                    n_out_st = lpht_pkg::ST_FULL;
                                end
                            end
                            lpht_pkg::OP_REMOVE: begin
                                if (r_found) begin
                                    n_out_st     = lpht_pkg::ST_OK;
                                    mem_we       = 1'b1;
                                    mem_wa       = r_fpos;
                                    mem_wd.mark  = lpht_pkg::MARK_TOMB;
                                    mem_wd.len   = r_len;
                                    mem_wd.key   = r_key;
                                    mem_wd.value = r_fval;
                                    n_occ        = r_occ - CW'(1);
                                end else begin
                                    n_out_st = lpht_pkg::ST_NOT_FOUND;
                                end
                            end
                            lpht_pkg::OP_LOOKUP: begin
                                if (r_found) begin
                                    n_out_st  = lpht_pkg::ST_OK;
                                    n_out_val = r_fval;
                                end else begin
                                    n_out_st = lpht_pkg::ST_NOT_FOUND;
                                end
                            end
                            default: n_out_st = lpht_pkg::ST_OK;
                        endcase
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rd <= mem[r_p];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpht_pkg::S_CLEAR;
            r_cap       <= lpht_pkg::CAP_RESET;
            r_occ       <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cap       <= n_cap;
            r_occ       <= n_occ;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_op      <= n_op;
        r_key     <= n_key;
        r_len     <= n_len;
        r_val     <= n_val;
        r_early   <= n_early;
        r_st      <= n_st;
        r_p       <= n_p;
        r_n       <= n_n;
        r_found   <= n_found;
        r_fpos    <= n_fpos;
        r_fval    <= n_fval;
        r_free_ok <= n_free_ok;
        r_free    <= n_free;
        r_out_st  <= n_out_st;
        r_out_val <= n_out_val;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_st;
    assign o_value_out = r_out_val;

    // memory is written only by the clearing pass or when a result is loaded
    a_write_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == lpht_pkg::S_CLEAR) || (r_state == lpht_pkg::S_RESP && out_free))
        else $error("slot write outside clear or response");

    // home slot lies inside the effective capacity
    a_home_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        u_done |-> (32'(u_slot) < 32'(cap_eff)))
        else $error("home slot out of range");

    // a successful insert bumps the live count by one
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lpht_pkg::S_RESP && out_free && !r_early &&
         r_op == lpht_pkg::OP_INSERT && !r_found && r_free_ok)
        |=> (r_occ == $past(r_occ) + CW'(1)))
        else $error("live count not incremented");

    // only a successful lookup carries a nonzero value
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != lpht_pkg::ST_OK) |-> (o_value_out == '0))
        else $error("value on failed request");

    // input is never taken while an item is in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lpht_pkg::S_HASH || r_state == lpht_pkg::S_FETCH ||
         r_state == lpht_pkg::S_CHECK) |-> !in_acc)
        else $error("item accepted mid-walk");

endmodule
